/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst, a, b)
`define CHK_NEXT(label, clk, rst, a, b)
`endif
`endif

/* hw/rtl/mvsm_pkg.sv */
package mvsm_pkg;
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP = 3'd2;
  localparam logic [2:0] OP_PITCH = 3'd3;
  localparam logic [2:0] OP_RENDER = 3'd4;
  localparam logic [23:0] STEP_ONE = 24'd65536;
  localparam logic [23:0] STEP_MIN = 24'd6554;
  localparam logic signed [17:0] SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN = -18'sd32768;
  // Frame addresses are 16 bits wide, so the memory depth is fixed.
  localparam int SAMPLE_FRAMES = 65536;

  typedef struct packed {
    logic [2:0] opcode;
    logic [15:0] sample_address;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [3:0] voice_index;
    logic [15:0] clip_start;
    logic [16:0] clip_length;
    logic [15:0] volume_left;
    logic [15:0] volume_right;
    logic [23:0] pitch;
    logic signed [15:0] loop_count;
  } req_t;

  typedef struct packed {
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic frame_valid;
    logic [3:0] granted_slot;
    logic slot_granted;
  } rsp_t;
endpackage

/* hw/rtl/multi_voice_sample_mixer.sv */
// Writes, stops, pitch changes and unused codes go straight to the response; a start first
// scans the voices for a free one. A render walks every voice, and each active voice reads
// two frames and uses the multiplier in turn; the memory port and the shared multiplier
// set that pace. One request is worked on at a time, and the next one can be taken in the
// same cycle the response appears; a waiting response does not block the input.
// Reset (rst, synchronous) clears all voices; the sample memory is not cleared.
`include "assert_macros.svh"
module multi_voice_sample_mixer #(
  parameter int VOICE_COUNT = 16
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input mvsm_pkg::req_t in_data,
  output logic out_valid,
  input logic out_stall,
  output mvsm_pkg::rsp_t out_data
);
  import mvsm_pkg::*;

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW = $clog2(SAMPLE_FRAMES);

  // The sequencer walks the voices; each active voice reads two frames from the
  // memory port, then the single multiplier does four lerp products and two
  // gain products in turn.
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHK, S_RDA, S_RDB, S_WAIT,
    S_M0, S_M1, S_M2, S_M3, S_G0, S_G1, S_ADV, S_DONE
  } state_t;

  state_t state;
  req_t req;
  logic [VW:0] vi;
  logic [VOICE_COUNT-1:0] active;
  logic [39:0] pos [VOICE_COUNT];
  logic [23:0] step [VOICE_COUNT];
  logic [15:0] gl [VOICE_COUNT];
  logic [15:0] gr [VOICE_COUNT];
  logic signed [15:0] rep [VOICE_COUNT];
  logic [15:0] base [VOICE_COUNT];
  logic [16:0] frames [VOICE_COUNT];
  logic [31:0] mem [SAMPLE_FRAMES];
  logic [31:0] rd_data;
  logic [31:0] fa, fb;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic [16:0] ia, ib;
  logic [15:0] frac;
  logic signed [49:0] acc_l, acc_r;
  logic signed [17:0] ml, mr;
  logic signed [35:0] prod;
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [15:0] sl, sr;

  logic [VW-1:0] cv;
  assign cv = vi[VW-1:0];
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
    if (state == S_IDLE && in_valid && !in_stall && in_data.opcode == OP_WRITE) begin
      mem[in_data.sample_address[AW-1:0]] <= {in_data.sample_right, in_data.sample_left};
    end
  end

  // Shared signed multiplier: operands chosen by state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M0: begin mul_a = 18'(signed'(fa[15:0])); mul_b = 18'sd65536 - $signed({2'b0, frac}); end
      S_M1: begin mul_a = 18'(signed'(fb[15:0])); mul_b = $signed({2'b0, frac}); end
      S_M2: begin mul_a = 18'(signed'(fa[31:16])); mul_b = 18'sd65536 - $signed({2'b0, frac}); end
      S_M3: begin mul_a = 18'(signed'(fb[31:16])); mul_b = $signed({2'b0, frac}); end
      S_G0: begin mul_a = 18'(sl); mul_b = $signed({2'b0, gl[cv]}); end
      S_G1: begin mul_a = 18'(sr); mul_b = $signed({2'b0, gr[cv]}); end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  function automatic logic signed [15:0] tdiv16(input logic signed [49:0] v);
    logic signed [49:0] t;
    t = v + ((v < 0) ? 50'sd65535 : 50'sd0);
    return 16'(t >>> 16);
  endfunction

  function automatic logic signed [17:0] sat_add(input logic signed [17:0] a,
                                                 input logic signed [49:0] p);
    logic signed [49:0] t, s;
    t = p + ((p < 0) ? 50'sd32767 : 50'sd0);
    s = 50'(a) + (t >>> 15);
    if (s > 50'(SAT_MAX)) return SAT_MAX;
    if (s < 50'(SAT_MIN)) return SAT_MIN;
    return 18'(s);
  endfunction

  always_comb begin
    rd_en = (state == S_RDA) || (state == S_RDB);
    rd_addr = AW'(base[cv] + ((state == S_RDA) ? ia[15:0] : ib[15:0]));
    sl = tdiv16(acc_l);
    sr = tdiv16(acc_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        pos[i] <= '0; step[i] <= STEP_ONE; gl[i] <= '0; gr[i] <= '0;
        rep[i] <= '0; base[i] <= '0; frames[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req <= in_data;
            vi <= '0;
            ml <= '0;
            mr <= '0;
            if (in_data.opcode == OP_START) state <= S_SCAN;
            else if (in_data.opcode == OP_RENDER) state <= S_CHK;
            else begin
              if (in_data.opcode == OP_STOP && 32'(in_data.voice_index) < VOICE_COUNT)
                active[VW'(in_data.voice_index)] <= 1'b0;
              if (in_data.opcode == OP_PITCH && 32'(in_data.voice_index) < VOICE_COUNT)
                step[VW'(in_data.voice_index)] <=
                  (in_data.pitch < STEP_MIN) ? STEP_MIN : in_data.pitch;
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (32'(vi) >= VOICE_COUNT) begin
            state <= S_DONE;
          end else if (!active[cv]) begin
            active[cv] <= 1'b1;
            pos[cv] <= '0;
            step[cv] <= STEP_ONE;
            gl[cv] <= req.volume_left;
            gr[cv] <= req.volume_right;
            rep[cv] <= req.loop_count;
            base[cv] <= req.clip_start;
            frames[cv] <= req.clip_length;
            state <= S_DONE;
          end else begin
            vi <= vi + 1'b1;
          end
        end
        S_CHK: begin
          if (32'(vi) >= VOICE_COUNT) begin
            state <= S_DONE;
          end else if (!active[cv]) begin
            vi <= vi + 1'b1;
          end else if (frames[cv] == '0) begin
            active[cv] <= 1'b0;
            vi <= vi + 1'b1;
          end else if (pos[cv][39:16] >= 24'(frames[cv])) begin
            if (rep[cv] == '0) begin
              active[cv] <= 1'b0;
              vi <= vi + 1'b1;
            end else begin
              if (rep[cv] > 0) rep[cv] <= rep[cv] - 16'sd1;
              pos[cv] <= '0;
              ia <= '0;
              frac <= '0;
              ib <= (frames[cv] > 17'd1) ? 17'd1 : 17'd0;
              state <= S_RDA;
            end
          end else begin
            ia <= pos[cv][32:16];
            frac <= pos[cv][15:0];
            ib <= (pos[cv][32:16] + 17'd1 > frames[cv] - 17'd1) ?
                  frames[cv] - 17'd1 : pos[cv][32:16] + 17'd1;
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin fa <= rd_data; state <= S_WAIT; end
        S_WAIT: begin fb <= rd_data; state <= S_M0; end
        S_M0: begin acc_l <= 50'(prod); state <= S_M1; end
        S_M1: begin acc_l <= acc_l + 50'(prod); state <= S_M2; end
        S_M2: begin acc_r <= 50'(prod); state <= S_M3; end
        S_M3: begin acc_r <= acc_r + 50'(prod); state <= S_G0; end
        S_G0: begin ml <= sat_add(ml, 50'(prod)); state <= S_G1; end
        S_G1: begin mr <= sat_add(mr, 50'(prod)); state <= S_ADV; end
        S_ADV: begin
          pos[cv] <= pos[cv] + 40'(step[cv]);
          vi <= vi + 1'b1;
          state <= S_CHK;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data.mix_left <= (req.opcode == OP_RENDER) ? 16'(ml) : '0;
            out_data.mix_right <= (req.opcode == OP_RENDER) ? 16'(mr) : '0;
            out_data.frame_valid <= (req.opcode == OP_RENDER);
            out_data.slot_granted <= (req.opcode == OP_START) && (32'(vi) < VOICE_COUNT);
            out_data.granted_slot <= ((req.opcode == OP_START) && (32'(vi) < VOICE_COUNT)) ?
                                     4'(vi) : 4'd0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPLY(a_busy_stall, clk, rst, state != S_IDLE, in_stall)
  `CHK_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `CHK_IMPLY(a_sat_l, clk, rst, state != S_IDLE, ml <= SAT_MAX && ml >= SAT_MIN)
endmodule
